/* design/lkv_pkg.sv */
package lkv_pkg;

    // Storage sizing
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W      = IDX_W;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Request codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // Value returned by a get miss
    localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);

    typedef logic [MAX_ENTRIES-1:0] t_vec;

    typedef enum logic [0:0] {
        S_IDLE,
        S_UPDATE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic apply;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

/* design/lkv_if.sv */
interface lkv_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [lkv_pkg::DATA_W-1:0]   lookup_key;
    logic signed [lkv_pkg::DATA_W-1:0]   write_value;

    modport source (output valid, output req_type, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input req_type, input lookup_key, input write_value,
                    output ready);
endinterface

interface lkv_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [lkv_pkg::DATA_W-1:0]   read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

/* design/lkv_ctrl.sv */
module lkv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  lkv_pkg::t_dp_status i_status,
    output lkv_pkg::t_dp_cmd    o_cmd
);

    lkv_pkg::t_state r_state;
    lkv_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: accept in idle, update once the result slot is free
    always_comb begin
        n_state = r_state;
        case (r_state)
            lkv_pkg::S_IDLE: begin
                if (i_req_valid) n_state = lkv_pkg::S_UPDATE;
            end
            lkv_pkg::S_UPDATE: begin
                if (!i_status.out_busy) n_state = lkv_pkg::S_IDLE;
            end
            default: n_state = lkv_pkg::S_IDLE;
        endcase
    end

    // Outputs; no request beat is taken while reset is held
    always_comb begin
        o_req_ready   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.apply   = 1'b0;
        case (r_state)
            lkv_pkg::S_IDLE: begin
                o_req_ready   = i_rst_n;
                o_cmd.capture = i_rst_n && i_req_valid;
            end
            lkv_pkg::S_UPDATE: begin
                o_cmd.apply = !i_status.out_busy;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/lkv_dp.sv */
module lkv_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkv_pkg::t_dp_cmd                  i_cmd,
    output lkv_pkg::t_dp_status               o_status,
    input  logic                              i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic                              i_req_type,
    input  logic signed [lkv_pkg::DATA_W-1:0] i_lookup_key,
    input  logic signed [lkv_pkg::DATA_W-1:0] i_write_value,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_ready,
    output logic                              o_rsp_hit,
    output logic signed [lkv_pkg::DATA_W-1:0] o_rsp_read_value
);

    localparam int N = lkv_pkg::MAX_ENTRIES;

    // Entry store
    lkv_pkg::t_vec                    r_valid;
    logic [lkv_pkg::DATA_W-1:0]       r_key  [N];
    logic [lkv_pkg::DATA_W-1:0]       r_val  [N];
    logic [lkv_pkg::RANK_W-1:0]       r_rank [N];
    logic [lkv_pkg::CNT_W-1:0]        r_count;
    logic [lkv_pkg::CAP_W-1:0]        r_cap;

    // Captured request and match vector
    logic                             r_req_type;
    logic [lkv_pkg::DATA_W-1:0]       r_req_key;
    logic [lkv_pkg::DATA_W-1:0]       r_req_val;
    lkv_pkg::t_vec                    r_match;

    // Result register
    logic                             r_out_valid;
    logic                             r_out_hit;
    logic signed [lkv_pkg::DATA_W-1:0] r_out_value;

    logic                             hit;
    logic [lkv_pkg::IDX_W-1:0]        hit_idx;
    logic [lkv_pkg::RANK_W-1:0]       hit_rank;
    logic [lkv_pkg::CMP_W-1:0]        eff_cap;
    logic                             full;
    logic [lkv_pkg::CNT_W-1:0]        cnt_m1;
    lkv_pkg::t_vec                    victim;
    lkv_pkg::t_vec                    valid_left;
    lkv_pkg::t_vec                    free_oh;
    logic                             do_insert;

    // Clamp capacity to 1 .. MAX_ENTRIES
    always_comb begin
        eff_cap = lkv_pkg::CMP_W'(r_cap);
        if (r_cap == '0) eff_cap = lkv_pkg::CMP_W'(1);
        if (eff_cap > lkv_pkg::CMP_W'(N)) eff_cap = lkv_pkg::CMP_W'(N);
    end

    // Hit decode: the match vector is one-hot or zero
    always_comb begin
        hit     = |r_match;
        hit_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (r_match[i]) hit_idx = hit_idx | lkv_pkg::IDX_W'(i);
        end
        hit_rank = r_rank[hit_idx];
    end

    // Eviction victim and lowest free slot
    always_comb begin
        full   = lkv_pkg::CMP_W'(r_count) >= eff_cap;
        cnt_m1 = r_count - lkv_pkg::CNT_W'(1);
        for (int i = 0; i < N; i++) begin
            victim[i] = full && r_valid[i] && (r_rank[i] == cnt_m1[lkv_pkg::RANK_W-1:0]);
        end
        valid_left = r_valid & ~victim;
        free_oh    = ~valid_left & (valid_left + lkv_pkg::t_vec'(1));
        do_insert  = i_cmd.apply && (r_req_type == lkv_pkg::REQ_PUT) && !hit;
    end

    // Capacity, valid bits and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= lkv_pkg::CAP_RESET;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (do_insert) begin
                r_valid <= valid_left | free_oh;
                if (!full) r_count <= r_count + lkv_pkg::CNT_W'(1);
            end
        end
    end

    // Request capture with key broadcast compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_req_key  <= i_lookup_key;
            r_req_val  <= i_write_value;
            for (int i = 0; i < N; i++) begin
                r_match[i] <= r_valid[i] && (r_key[i] == i_lookup_key);
            end
        end
    end

    // Entry payload and recency update
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            for (int i = 0; i < N; i++) begin
                if (hit) begin
                    // promote the hit entry, age the more recent ones
                    if (r_match[i]) begin
                        r_rank[i] <= '0;
                        if (r_req_type == lkv_pkg::REQ_PUT) r_val[i] <= r_req_val;
                    end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                        r_rank[i] <= r_rank[i] + lkv_pkg::RANK_W'(1);
                    end
                end else if (r_req_type == lkv_pkg::REQ_PUT) begin
                    // insert as most recent, age the survivors
                    if (free_oh[i]) begin
                        r_key[i]  <= r_req_key;
                        r_val[i]  <= r_req_val;
                        r_rank[i] <= '0;
                    end else if (valid_left[i]) begin
                        r_rank[i] <= r_rank[i] + lkv_pkg::RANK_W'(1);
                    end
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out_hit <= hit;
            if (r_req_type == lkv_pkg::REQ_PUT) begin
                r_out_value <= '0;
            end else if (hit) begin
                r_out_value <= r_val[hit_idx];
            end else begin
                r_out_value <= lkv_pkg::MISS_VALUE;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && !i_rsp_ready;
    assign o_rsp_valid       = r_out_valid;
    assign o_rsp_hit         = r_out_hit;
    assign o_rsp_read_value  = r_out_value;

endmodule

/* design/lru_key_value_cache.sv */
// A result beat is registered when the recency update is applied; the request is
// matched against all keys in the accept cycle, and the recency ranks are updated
// in the update state that follows. No new request is accepted until that update
// is done. A result held by the sink delays that update, and with it the next accept.
// Reset (synchronous, active low) empties the store and sets capacity to 16.
module lru_key_value_cache (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_wdata,
    lkv_req_if.sink                   i_req,
    lkv_rsp_if.source                 o_rsp
);

    lkv_pkg::t_dp_cmd    cmd;
    lkv_pkg::t_dp_status status;
    logic                req_ready;

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lkv_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_type       (i_req.req_type),
        .i_lookup_key     (i_req.lookup_key),
        .i_write_value    (i_req.write_value),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_hit        (o_rsp.hit),
        .o_rsp_read_value (o_rsp.read_value)
    );

    assign i_req.ready = req_ready;

endmodule
